### rtl/chacha20_keystream_block_defines.svh
// ----------------------------------------------------------------------------
// chacha20 keystream block assertion macros
// shared concurrent check wrappers, clocked on clk with rst_n as disable
// ----------------------------------------------------------------------------
`ifndef CHACHA20_KEYSTREAM_BLOCK_DEFINES_SVH
`define CHACHA20_KEYSTREAM_BLOCK_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define CHK_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CHK_SAME(lbl, ante, cons, msg)
`define CHK_NEXT(lbl, ante, cons, msg)

`endif

`endif

### rtl/chacha_pkg.sv
// ----------------------------------------------------------------------------
// chacha_pkg
// state types, sigma constants and the half-round function of the block
// ----------------------------------------------------------------------------
package chacha_pkg;

    typedef logic [31:0]       word_t;
    typedef logic [15:0][31:0] state_t;
    typedef logic [2:0]        piece_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        KEY_PART_0 = 2'd0,
        KEY_PART_1 = 2'd1,
        KEY_PART_2 = 2'd2,
        KEY_PART_3 = 2'd3
    } cfg_idx_t;

    // "expand 32-byte k"
    localparam word_t SIGMA_0 = 32'h6170_7865;
    localparam word_t SIGMA_1 = 32'h3320_646e;
    localparam word_t SIGMA_2 = 32'h7962_2d32;
    localparam word_t SIGMA_3 = 32'h6b20_6574;

    localparam piece_t LAST_PIECE = 3'd7;

    // one half of a column or diagonal round: the first half rotates by 16
    // and 12, the second by 8 and 7
    function automatic state_t half_round(state_t s, logic diag, logic second);
        state_t     r;
        logic [1:0] i2;
        logic [1:0] o1;
        logic [1:0] o2;
        logic [1:0] o3;
        logic [3:0] ia;
        logic [3:0] ib;
        logic [3:0] ic;
        logic [3:0] id;
        word_t      a;
        word_t      b;
        word_t      c;
        word_t      d;
        r = s;
        for (int i = 0; i < 4; i++)
        begin
            i2 = 2'(i);
            o1 = diag ? 2'd1 : 2'd0;
            o2 = diag ? 2'd2 : 2'd0;
            o3 = diag ? 2'd3 : 2'd0;
            ia = {2'b00, i2};
            ib = {2'b01, 2'(i2 + o1)};
            ic = {2'b10, 2'(i2 + o2)};
            id = {2'b11, 2'(i2 + o3)};
            a = s[ia];
            b = s[ib];
            c = s[ic];
            d = s[id];
            a = a + b;
            d = d ^ a;
            d = second ? {d[23:0], d[31:24]} : {d[15:0], d[31:16]};
            c = c + d;
            b = b ^ c;
            b = second ? {b[24:0], b[31:25]} : {b[19:0], b[31:20]};
            r[ia] = a;
            r[ib] = b;
            r[ic] = c;
            r[id] = d;
        end
        return r;
    endfunction

endpackage

### rtl/chacha20_keystream_block.sv
// a request passes the half-round stages, the block buffer and the output
// piece register on its way out; each block leaves as eight 64-bit pieces
// the round pipeline takes a new item every cycle while the serializer is free
// reset: all valid bits and the key registers clear, no clearing pass
// ----------------------------------------------------------------------------
// chacha20_keystream_block
// rfc 8439 block function: 4*DOUBLE_ROUNDS half-round pipeline stages,
// final state add into a block buffer, then eight little-endian pieces out
// ----------------------------------------------------------------------------
`include "chacha20_keystream_block_defines.svh"

module chacha20_keystream_block #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] nonce_low,
    input  logic [31:0] nonce_high,
    input  logic [31:0] block_counter,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] keystream_pair,
    output logic [2:0]  piece_index,
    output logic        last_piece
);

    // one stage per half round, two half rounds per round
    localparam int NSTG = 4 * DOUBLE_ROUNDS;

    // ------------------------------------------------------------------
    // key registers
    // ------------------------------------------------------------------
    logic [3:0][63:0] key_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (chacha_pkg::cfg_idx_t'(cfg_index))
                chacha_pkg::KEY_PART_0: key_reg[0] <= cfg_data;
                chacha_pkg::KEY_PART_1: key_reg[1] <= cfg_data;
                chacha_pkg::KEY_PART_2: key_reg[2] <= cfg_data;
                chacha_pkg::KEY_PART_3: key_reg[3] <= cfg_data;
                default:                key_reg    <= key_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // initial state: sigma, key, counter, nonce
    // ------------------------------------------------------------------
    function automatic chacha_pkg::state_t init_state(logic [3:0][63:0] key,
                                                      logic [31:0] ctr,
                                                      logic [63:0] nlo,
                                                      logic [31:0] nhi);
        chacha_pkg::state_t s;
        s[0]  = chacha_pkg::SIGMA_0;
        s[1]  = chacha_pkg::SIGMA_1;
        s[2]  = chacha_pkg::SIGMA_2;
        s[3]  = chacha_pkg::SIGMA_3;
        s[4]  = key[0][31:0];
        s[5]  = key[0][63:32];
        s[6]  = key[1][31:0];
        s[7]  = key[1][63:32];
        s[8]  = key[2][31:0];
        s[9]  = key[2][63:32];
        s[10] = key[3][31:0];
        s[11] = key[3][63:32];
        s[12] = ctr;
        s[13] = nlo[31:0];
        s[14] = nlo[63:32];
        s[15] = nhi;
        return s;
    endfunction

    // ------------------------------------------------------------------
    // round pipeline; the whole pipe moves together when the tail can
    // leave or is empty, so a stall freezes every stage in place
    // ------------------------------------------------------------------
    chacha_pkg::state_t            st_reg   [NSTG];
    logic [NSTG-1:0]               vld_reg;
    logic [127:0]                  aux_reg  [NSTG]; // counter and nonce
    logic                          pipe_en;
    logic                          ser_take;
    logic                          tail_valid;

    assign tail_valid = vld_reg[NSTG-1];
    assign pipe_en    = !tail_valid || ser_take;
    assign in_stall   = !pipe_en;

    genvar j;
    generate
        for (j = 0; j < NSTG; j++)
        begin : g_stage
            localparam logic DIAG   = ((j / 2) % 2) == 1;
            localparam logic SECOND = (j % 2) == 1;

            chacha_pkg::state_t st_in;
            logic [127:0]       aux_in;
            logic               vld_in;

            if (j == 0)
            begin : g_head
                assign st_in  = init_state(key_reg, block_counter, nonce_low,
                                           nonce_high);
                assign aux_in = {nonce_high, nonce_low, block_counter};
                assign vld_in = in_valid;
            end
            else
            begin : g_body
                assign st_in  = st_reg[j-1];
                assign aux_in = aux_reg[j-1];
                assign vld_in = vld_reg[j-1];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[j] <= 1'b0;
                end
                else if (pipe_en)
                begin
                    vld_reg[j] <= vld_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (pipe_en)
                begin
                    st_reg[j]  <= chacha_pkg::half_round(st_in, DIAG, SECOND);
                    aux_reg[j] <= aux_in;
                end
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // feed-forward add into the block buffer; the user must not change the key while
    // a block is in flight (not enforced here), as it is read straight from the key registers
    // ------------------------------------------------------------------
    chacha_pkg::state_t tail_init;
    chacha_pkg::state_t blk_next;

    assign tail_init = init_state(key_reg, aux_reg[NSTG-1][31:0],
                                  aux_reg[NSTG-1][95:32],
                                  aux_reg[NSTG-1][127:96]);

    always_comb
    begin
        for (int w = 0; w < 16; w++)
        begin
            blk_next[w] = st_reg[NSTG-1][w] + tail_init[w];
        end
    end

    // ------------------------------------------------------------------
    // serializer: block buffer plus a registered output piece
    // ------------------------------------------------------------------
    chacha_pkg::state_t  blk_reg;
    logic                blk_valid_reg;
    chacha_pkg::piece_t  cnt_reg;
    logic                out_valid_reg;
    logic [63:0]         pair_reg;
    chacha_pkg::piece_t  piece_reg;
    logic                last_reg;
    logic                out_free;
    logic                piece_move;
    logic                blk_done;
    logic                blk_load;

    assign out_free   = !out_valid_reg || !out_stall;
    assign piece_move = blk_valid_reg && out_free;
    assign blk_done   = piece_move && (cnt_reg == chacha_pkg::LAST_PIECE);
    assign ser_take   = !blk_valid_reg || blk_done;
    assign blk_load   = tail_valid && ser_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (blk_load)
            begin
                blk_valid_reg <= 1'b1;
                cnt_reg       <= '0;
            end
            else if (blk_done)
            begin
                blk_valid_reg <= 1'b0;
                cnt_reg       <= '0;
            end
            else if (piece_move)
            begin
                cnt_reg <= cnt_reg + 3'd1;
            end

            if (out_free)
            begin
                out_valid_reg <= blk_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (blk_load)
        begin
            blk_reg <= blk_next;
        end
        if (piece_move)
        begin
            // word 2k in the low half, word 2k+1 in the high half
            pair_reg  <= {blk_reg[{cnt_reg, 1'b1}], blk_reg[{cnt_reg, 1'b0}]};
            piece_reg <= cnt_reg;
            last_reg  <= (cnt_reg == chacha_pkg::LAST_PIECE);
        end
    end

    assign out_valid      = out_valid_reg;
    assign keystream_pair = pair_reg;
    assign piece_index    = piece_reg;
    assign last_piece     = last_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `CHK_NEXT(a_piece_seq, out_valid_reg && !out_stall && !last_reg, out_valid_reg && (piece_reg == ($past(piece_reg) + 3'd1)), "piece order broken")
    `CHK_SAME(a_last_flag, out_valid_reg, last_reg == (piece_reg == chacha_pkg::LAST_PIECE), "last flag mismatch")
    `CHK_SAME(a_stall_cause, in_stall, tail_valid && blk_valid_reg, "input stalled with free pipeline")
    `CHK_NEXT(a_blk_hold, blk_valid_reg && !blk_done, blk_valid_reg && $stable(blk_reg), "block buffer changed mid-block")

endmodule

### tb/chacha20_keystream_block_tb.sv
// ----------------------------------------------------------------------------
// chacha20_keystream_block_tb
// checks every keystream piece of the block against an in-bench chacha20
// block function, over several keys and sender/receiver idle patterns
// ----------------------------------------------------------------------------
module chacha20_keystream_block_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import chacha_pkg::*;

    localparam int ROUND_PAIRS  = 10;
    // input transfer to first piece, plus slack for the serializer
    localparam int DRAIN_CYCLES = 4 * ROUND_PAIRS + 2 + 16;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int RANDOM_ITEMS = 25;
    localparam int FLOOD_ITEMS  = 60;
    localparam int REPORT_LIMIT = 10;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct packed {
        logic [63:0] nonce_low;
        logic [31:0] nonce_high;
        logic [31:0] block_counter;
    } block_req_t;

    typedef struct packed {
        logic [63:0] data;
        piece_t      index;
        logic        last;
    } piece_rec_t;

    typedef logic [7:0][63:0] keystream_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = KEY_PART_0;
    logic [63:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [63:0] nonce_low = '0;
    logic [31:0] nonce_high = '0;
    logic [31:0] block_counter = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [63:0] keystream_pair;
    logic [2:0]  piece_index;
    logic        last_piece;

    // bench copy of the key registers, reset value zero
    logic [3:0][63:0] key_regs = '0;
    cfg_idx_t         key_index [4] = '{KEY_PART_0, KEY_PART_1, KEY_PART_2, KEY_PART_3};

    block_req_t pending_requests [$];
    piece_rec_t expected_pieces [$];
    idle_mode_t idle_mode = IDLE_NONE;
    logic       hold_request = 1'b0;
    int         hold_left = 0;
    int         mismatch_count = 0;
    int         cycle_count = 0;

    chacha20_keystream_block #(
        .DOUBLE_ROUNDS (ROUND_PAIRS)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .nonce_low      (nonce_low),
        .nonce_high     (nonce_high),
        .block_counter  (block_counter),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .keystream_pair (keystream_pair),
        .piece_index    (piece_index),
        .last_piece     (last_piece)
    );

    // 12 ns clock
    initial
    begin
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // chacha20 block function
    // ------------------------------------------------------------------------

    function automatic word_t rotl(word_t x, int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic state_t quarter_mix(state_t s, int a, int b, int c, int d);
        s[a] = s[a] + s[b];
        s[d] = rotl(s[d] ^ s[a], 16);
        s[c] = s[c] + s[d];
        s[b] = rotl(s[b] ^ s[c], 12);
        s[a] = s[a] + s[b];
        s[d] = rotl(s[d] ^ s[a], 8);
        s[c] = s[c] + s[d];
        s[b] = rotl(s[b] ^ s[c], 7);
        return s;
    endfunction

    function automatic keystream_t chacha_keystream(logic [3:0][63:0] key, block_req_t req);
        state_t     init_words;
        state_t     mix;
        keystream_t ks;
        init_words[0] = SIGMA_0;
        init_words[1] = SIGMA_1;
        init_words[2] = SIGMA_2;
        init_words[3] = SIGMA_3;
        for (int i = 0; i < 4; i++)
        begin
            init_words[4 + 2 * i] = key[i][31:0];
            init_words[5 + 2 * i] = key[i][63:32];
        end
        // counter goes in as is, no carry into the nonce
        init_words[12] = req.block_counter;
        init_words[13] = req.nonce_low[31:0];
        init_words[14] = req.nonce_low[63:32];
        init_words[15] = req.nonce_high;
        mix = init_words;
        for (int r = 0; r < ROUND_PAIRS; r++)
        begin
            // column round
            mix = quarter_mix(mix, 0, 4, 8, 12);
            mix = quarter_mix(mix, 1, 5, 9, 13);
            mix = quarter_mix(mix, 2, 6, 10, 14);
            mix = quarter_mix(mix, 3, 7, 11, 15);
            // diagonal round
            mix = quarter_mix(mix, 0, 5, 10, 15);
            mix = quarter_mix(mix, 1, 6, 11, 12);
            mix = quarter_mix(mix, 2, 7, 8, 13);
            mix = quarter_mix(mix, 3, 4, 9, 14);
        end
        for (int i = 0; i < 16; i++)
            mix[i] = mix[i] + init_words[i];
        // even word in the low half of each piece
        for (int k = 0; k < 8; k++)
            ks[k] = {mix[2 * k + 1], mix[2 * k]};
        return ks;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    function automatic logic [63:0] pick_wide();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    task automatic add_request(logic [63:0] nl, logic [31:0] nh, logic [31:0] bc);
        pending_requests.push_back('{nl, nh, bc});
    endtask

    task automatic add_random_requests(int count);
        for (int i = 0; i < count; i++)
            add_request(pick_wide(), pick_word(), pick_word());
    endtask

    // key writes only while the block is idle
    task automatic program_key(logic [3:0][63:0] key);
        for (int i = 0; i < 4; i++)
        begin
            @(posedge clk);
            cfg_write <= 1'b1;
            cfg_index <= key_index[i];
            cfg_data  <= key[i];
            key_regs[i] = key[i];
        end
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // sampled on the falling edge, away from the driver and the monitor
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_requests.size() != 0 || in_valid || expected_pieces.size() != 0);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic sender_idles();
        case (idle_mode)
            IDLE_SENDER: return $urandom_range(99) < 86;
            IDLE_BOTH:   return $urandom_range(99) < 24;
            default:     return 1'b0;
        endcase
    endfunction

    function automatic logic receiver_stalls();
        case (idle_mode)
            IDLE_RECEIVER: return $urandom_range(99) < 86;
            IDLE_BOTH:     return $urandom_range(99) < 24;
            default:       return 1'b0;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // driver: one request per input transfer, valid held while stalled
    // ------------------------------------------------------------------------

    always @(posedge clk)
    begin : request_driver
        block_req_t req;
        keystream_t ks;
        logic       offer;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            // transfer: queue the eight pieces this block must produce
            if (in_valid && !in_stall)
            begin
                ks = chacha_keystream(key_regs, '{nonce_low, nonce_high, block_counter});
                for (int k = 0; k < 8; k++)
                    expected_pieces.push_back('{ks[k], piece_t'(k), piece_t'(k) == LAST_PIECE});
            end
            if (!in_valid || !in_stall)
            begin
                offer = pending_requests.size() != 0 && !sender_idles();
                if (offer)
                begin
                    req = pending_requests.pop_front();
                    nonce_low     <= req.nonce_low;
                    nonce_high    <= req.nonce_high;
                    block_counter <= req.block_counter;
                end
                in_valid <= offer;
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor and receiver stall
    // ------------------------------------------------------------------------

    task automatic note_mismatch(string what, piece_rec_t want, piece_rec_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: %s: expected data %h index %0d last %0b, got data %h index %0d last %0b",
                     $realtime, what, want.data, want.index, want.last,
                     got.data, got.index, got.last);
    endtask

    always @(posedge clk)
    begin : piece_monitor
        piece_rec_t got;
        piece_rec_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got = '{keystream_pair, piece_index, last_piece};
                if (expected_pieces.size() == 0)
                    note_mismatch("piece with nothing pending", '0, got);
                else
                begin
                    want = expected_pieces.pop_front();
                    if (got.data !== want.data || got.index !== want.index
                        || got.last !== want.last)
                        note_mismatch("keystream piece mismatch", want, got);
                end
            end
            // long hold-off, counted here, overrides the random stall
            if (hold_request)
                hold_left <= HOLD_CYCLES;
            else if (hold_left != 0)
                hold_left <= hold_left - 1;
            out_stall <= hold_request || hold_left > 1 || receiver_stalls();
        end
    end

    // ------------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------------

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------

    initial
    begin : test_sequence
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // key at its reset value, field extremes, no idling
        @(negedge clk);
        idle_mode = IDLE_NONE;
        add_request('0, '0, '0);
        add_request('1, '1, '1);
        add_request('1, '1, '0);
        add_request('0, '0, '1);
        add_request(64'haaaa_aaaa_aaaa_aaaa, 32'h5555_5555, 32'h8000_0000);
        add_request(64'h5555_5555_5555_5555, 32'haaaa_aaaa, 32'h0000_0001);
        add_request(64'h8000_0000_0000_0001, 32'h8000_0001, 32'h7fff_ffff);
        add_request(64'h0000_0001_ffff_ffff, 32'h0000_0001, 32'hffff_fffe);
        wait_drained();

        // sequential key bytes, published block function vectors
        program_key({64'h1f1e_1d1c_1b1a_1918, 64'h1716_1514_1312_1110,
                     64'h0f0e_0d0c_0b0a_0908, 64'h0706_0504_0302_0100});
        @(negedge clk);
        add_request(64'h4a00_0000_0900_0000, 32'h0000_0000, 32'h0000_0001);
        add_request(64'h4a00_0000_0000_0000, 32'h0000_0000, 32'h0000_0001);
        add_request(64'h4a00_0000_0000_0000, 32'h0000_0000, 32'h0000_0002);
        // counter at its top: no carry into the nonce words
        add_request(64'h4a00_0000_0000_0000, 32'h0000_0000, 32'hffff_ffff);
        add_request(64'h4a00_0000_0000_0000, 32'h0000_0000, 32'h0000_0000);
        add_request(64'h4a00_0000_0000_0001, 32'h0000_0000, 32'h0000_0000);
        add_request('0, '1, '0);
        add_request('1, '0, '1);
        wait_drained();

        // all-ones key, sparse sender
        program_key('1);
        @(negedge clk);
        idle_mode = IDLE_SENDER;
        add_random_requests(RANDOM_ITEMS);
        wait_drained();

        // random key, slow receiver
        program_key({pick_wide(), pick_wide(), pick_wide(), pick_wide()});
        @(negedge clk);
        idle_mode = IDLE_RECEIVER;
        add_random_requests(RANDOM_ITEMS);
        wait_drained();

        // random key, both sides idle now and then
        program_key({pick_wide(), pick_wide(), pick_wide(), pick_wide()});
        @(negedge clk);
        idle_mode = IDLE_BOTH;
        add_random_requests(RANDOM_ITEMS);
        wait_drained();

        // random key, receiver holds off while the sender floods the pipeline
        program_key({pick_wide(), pick_wide(), pick_wide(), pick_wide()});
        @(negedge clk);
        idle_mode = IDLE_NONE;
        add_random_requests(FLOOD_ITEMS);
        hold_request = 1'b1;
        @(negedge clk);
        hold_request = 1'b0;
        wait_drained();

        // back to the reset key value, mixed idling
        program_key('0);
        @(negedge clk);
        idle_mode = IDLE_BOTH;
        add_random_requests(RANDOM_ITEMS);
        wait_drained();

        // let any stray piece show up before the verdict
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        if (expected_pieces.size() != 0)
            mismatch_count++;

        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
